[hdl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the price swing cycle tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int MAX_PIVOTS = 65536;
    localparam int POS_W      = $clog2(MAX_PIVOTS);
    localparam int PRICE_W    = 32;
    localparam int TIME_W     = 32;
    localparam int BAR_W      = 32;
    localparam int BACK_W     = 16;
    localparam int STABLE_W   = 8;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [POS_W-1:0]    POS_LAST        = POS_W'(MAX_PIVOTS - 1);
    localparam logic [STABLE_W-1:0] REPEAT_MAX      = '1;
    localparam logic [BACK_W-1:0]   MIN_BACK_RST    = 16'd360;
    localparam logic [STABLE_W-1:0] MIN_STABLE_RST  = 8'd7;

    typedef enum logic [0:0] {
        REG_BACK_LIMIT   = 1'b0,
        REG_STABLE_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [BAR_W-1:0]   bar_index;
        logic [PRICE_W-1:0] pivot_price;
        logic [TIME_W-1:0]  pivot_time;
        logic               oldest_pivot;
    } pivot_t;

    typedef struct packed {
        logic               found_any;
        logic [TIME_W-1:0]  fresh_begin_time;
        logic [TIME_W-1:0]  fresh_finish_time;
        logic [PRICE_W-1:0] fresh_begin_price;
        logic [PRICE_W-1:0] fresh_finish_price;
        logic               fresh_rising;
        logic [TIME_W-1:0]  main_begin_time;
        logic [TIME_W-1:0]  main_finish_time;
        logic [PRICE_W-1:0] main_begin_price;
        logic [PRICE_W-1:0] main_finish_price;
        logic               main_rising;
    } summary_t;

    typedef struct packed {
        logic [TIME_W-1:0]  begin_time;
        logic [TIME_W-1:0]  finish_time;
        logic [PRICE_W-1:0] begin_price;
        logic [PRICE_W-1:0] finish_price;
        logic               rising;
    } swing_t;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] begin_price;
        logic [PRICE_W-1:0] finish_price;
    } mark_t;

    typedef struct packed {
        logic   last;
        logic   has_swing;
        logic   stop_ok;
        swing_t swing;
    } beat_t;

    typedef struct packed {
        logic [BACK_W-1:0]   back_limit;
        logic [STABLE_W-1:0] stable_limit;
    } cfg_t;

endpackage

[hdl/price_swing_cycle_tracker.sv]
// ----------------------------------------------------------------------------
// price_swing_cycle_tracker
// Swing tracker over pivot sets given newest first; one summary per set.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  pivot     in         push / full               pivot_t
//  summary   out        pop / empty               summary_t
//  config    in         psel/penable/pwrite/...   two registers at 0x0, 0x4
//
//  One pivot per cycle while full is low; the front classifies in the accept cycle.
//  A flagged beat passes the beat queue, then its summary the result queue.
//  Beat queue and result queue hold two entries each; full rises on back-pressure.
//  rst_n clears control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module price_swing_cycle_tracker
    import pst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pivot_t            pivot,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output summary_t          summary,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    logic  fq_push, fq_full, fq_pop, fq_empty;
    beat_t fq_din, fq_head;

    pst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .pivot     (pivot),
        .full      (full),
        .beat_push (fq_push),
        .beat      (fq_din),
        .beat_full (fq_full)
    );

    pst_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_din),
        .full  (fq_full),
        .pop   (fq_pop),
        .empty (fq_empty),
        .head  (fq_head)
    );

    pst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .beat_empty (fq_empty),
        .beat       (fq_head),
        .beat_pop   (fq_pop),
        .pop        (pop),
        .empty      (empty),
        .summary    (summary)
    );

endmodule

[hdl/pst_cfg.sv]
// ----------------------------------------------------------------------------
// pst_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module pst_cfg
    import pst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_BACK_LIMIT:   cfg_next.back_limit   = pwdata[BACK_W-1:0];
                REG_STABLE_LIMIT: cfg_next.stable_limit = pwdata[STABLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BACK_LIMIT:   prdata = DATA_W'(cfg_reg.back_limit);
            REG_STABLE_LIMIT: prdata = DATA_W'(cfg_reg.stable_limit);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.back_limit   <= MIN_BACK_RST;
            cfg_reg.stable_limit <= MIN_STABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/pst_front.sv]
// ----------------------------------------------------------------------------
// pst_front
// Accept pivots, track the window extremes and classify each window.
// ----------------------------------------------------------------------------
module pst_front
    import pst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    input  pivot_t pivot,
    output logic  full,
    output logic  beat_push,
    output beat_t beat,
    input  logic  beat_full
);

    logic               awaiting_reg,  awaiting_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [BAR_W-1:0]   newest_reg,    newest_next;
    logic [PRICE_W-1:0] low_price_reg, low_price_next;
    logic [TIME_W-1:0]  low_time_reg,  low_time_next;
    logic [POS_W-1:0]   low_pos_reg,   low_pos_next;
    logic [PRICE_W-1:0] high_price_reg, high_price_next;
    logic [TIME_W-1:0]  high_time_reg, high_time_next;
    logic [POS_W-1:0]   high_pos_reg,  high_pos_next;
    logic [BAR_W:0]     reach;
    logic               accept;

    assign full      = beat_full;
    assign accept    = push && !beat_full;
    assign beat_push = accept;
    assign reach     = {1'b0, pivot.bar_index} + (BAR_W+1)'(cfg.back_limit);

    always_comb
    begin
        awaiting_next   = awaiting_reg;
        pos_next        = pos_reg;
        newest_next     = newest_reg;
        low_price_next  = low_price_reg;
        low_time_next   = low_time_reg;
        low_pos_next    = low_pos_reg;
        high_price_next = high_price_reg;
        high_time_next  = high_time_reg;
        high_pos_next   = high_pos_reg;
        beat            = '0;
        beat.last       = pivot.oldest_pivot;

        priority if (awaiting_reg)
        begin
            awaiting_next   = 1'b0;
            pos_next        = '0;
            newest_next     = pivot.bar_index;
            low_price_next  = pivot.pivot_price;
            high_price_next = pivot.pivot_price;
            low_time_next   = pivot.pivot_time;
            high_time_next  = pivot.pivot_time;
            low_pos_next    = '0;
            high_pos_next   = '0;
        end
        else if (pos_reg != POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pivot.pivot_price <= low_price_reg)
            begin
                low_price_next = pivot.pivot_price;
                low_time_next  = pivot.pivot_time;
                low_pos_next   = pos_next;
            end
            if (pivot.pivot_price >= high_price_reg)
            begin
                high_price_next = pivot.pivot_price;
                high_time_next  = pivot.pivot_time;
                high_pos_next   = pos_next;
            end
            beat.has_swing = 1'b1;
            beat.stop_ok   = reach < {1'b0, newest_reg};
            if (high_pos_next < low_pos_next)
            begin
                beat.swing.rising       = 1'b1;
                beat.swing.begin_price  = low_price_next;
                beat.swing.finish_price = high_price_next;
                beat.swing.begin_time   = low_time_next;
                beat.swing.finish_time  = high_time_next;
            end
            else
            begin
                beat.swing.rising       = 1'b0;
                beat.swing.begin_price  = high_price_next;
                beat.swing.finish_price = low_price_next;
                beat.swing.begin_time   = high_time_next;
                beat.swing.finish_time  = low_time_next;
            end
        end
        else
        begin
            // drop pivots past the set limit
            beat.has_swing = 1'b0;
        end

        if (pivot.oldest_pivot)
        begin
            awaiting_next = 1'b1;
            pos_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            pos_reg      <= '0;
        end
        else if (accept)
        begin
            awaiting_reg <= awaiting_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            newest_reg     <= newest_next;
            low_price_reg  <= low_price_next;
            low_time_reg   <= low_time_next;
            low_pos_reg    <= low_pos_next;
            high_price_reg <= high_price_next;
            high_time_reg  <= high_time_next;
            high_pos_reg   <= high_pos_next;
        end
    end

endmodule

[hdl/pst_queue.sv]
// ----------------------------------------------------------------------------
// pst_queue
// Two-entry queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module pst_queue
    import pst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t din,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output beat_t head
);

    beat_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hdl/pst_back.sv]
// ----------------------------------------------------------------------------
// pst_back
// Drop repeated swings, keep freshest and main swing, stop early, summarize.
// ----------------------------------------------------------------------------
module pst_back
    import pst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     beat_empty,
    input  beat_t    beat,
    output logic     beat_pop,
    input  logic     pop,
    output logic     empty,
    output summary_t summary
);

    logic                stopped_reg,  stopped_next;
    logic [STABLE_W-1:0] repeat_reg,   repeat_next;
    mark_t               up_reg,       up_next;
    mark_t               down_reg,     down_next;
    logic                have_reg,     have_next;
    swing_t              fresh_reg,    fresh_next;
    swing_t              main_reg,     main_next;
    mark_t               mark;
    logic                is_repeat;
    summary_t            sum_beat;

    summary_t            oq_reg [2];
    logic                oq_wr_reg, oq_rd_reg;
    logic [1:0]          oq_count_reg;
    logic                oq_full, oq_push, oq_pop;

    assign oq_full  = oq_count_reg == 2'd2;
    assign empty    = oq_count_reg == 2'd0;
    assign summary  = oq_reg[oq_rd_reg];
    assign beat_pop = !beat_empty && (!beat.last || !oq_full);
    assign oq_push  = beat_pop && beat.last;
    assign oq_pop   = pop && !empty;

    always_comb
    begin
        stopped_next = stopped_reg;
        repeat_next  = repeat_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        have_next    = have_reg;
        fresh_next   = fresh_reg;
        main_next    = main_reg;
        mark         = beat.swing.rising ? up_reg : down_reg;
        is_repeat    = mark.valid && mark.begin_price == beat.swing.begin_price
                       && mark.finish_price == beat.swing.finish_price;

        if (!stopped_reg && beat.has_swing)
        begin
            if (is_repeat)
            begin
                if (repeat_reg != REPEAT_MAX)
                begin
                    repeat_next = repeat_reg + STABLE_W'(1);
                end
            end
            else
            begin
                if (beat.swing.rising)
                begin
                    up_next = {1'b1, beat.swing.begin_price, beat.swing.finish_price};
                end
                else
                begin
                    down_next = {1'b1, beat.swing.begin_price, beat.swing.finish_price};
                end
                if (!have_reg)
                begin
                    have_next  = 1'b1;
                    fresh_next = beat.swing;
                    main_next  = beat.swing;
                end
                else
                begin
                    if (beat.swing.finish_time > fresh_reg.finish_time)
                    begin
                        fresh_next = beat.swing;
                    end
                    if (beat.swing.finish_time < main_reg.finish_time)
                    begin
                        main_next = beat.swing;
                    end
                end
            end
            if (beat.stop_ok && repeat_next >= cfg.stable_limit)
            begin
                stopped_next = 1'b1;
            end
        end

        sum_beat = '0;
        if (have_next)
        begin
            sum_beat.found_any          = 1'b1;
            sum_beat.fresh_begin_time   = fresh_next.begin_time;
            sum_beat.fresh_finish_time  = fresh_next.finish_time;
            sum_beat.fresh_begin_price  = fresh_next.begin_price;
            sum_beat.fresh_finish_price = fresh_next.finish_price;
            sum_beat.fresh_rising       = fresh_next.rising;
            sum_beat.main_begin_time    = main_next.begin_time;
            sum_beat.main_finish_time   = main_next.finish_time;
            sum_beat.main_begin_price   = main_next.begin_price;
            sum_beat.main_finish_price  = main_next.finish_price;
            sum_beat.main_rising        = main_next.rising;
        end

        if (beat.last)
        begin
            stopped_next   = 1'b0;
            repeat_next    = '0;
            up_next.valid  = 1'b0;
            down_next.valid = 1'b0;
            have_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg    <= 1'b0;
            repeat_reg     <= '0;
            up_reg         <= '0;
            down_reg       <= '0;
            have_reg       <= 1'b0;
            oq_wr_reg      <= 1'b0;
            oq_rd_reg      <= 1'b0;
            oq_count_reg   <= '0;
        end
        else
        begin
            if (beat_pop)
            begin
                stopped_reg    <= stopped_next;
                repeat_reg     <= repeat_next;
                up_reg         <= up_next;
                down_reg       <= down_next;
                have_reg       <= have_next;
            end
            oq_wr_reg    <= oq_wr_reg ^ oq_push;
            oq_rd_reg    <= oq_rd_reg ^ oq_pop;
            oq_count_reg <= oq_count_reg + 2'(oq_push) - 2'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_pop)
        begin
            fresh_reg             <= fresh_next;
            main_reg              <= main_next;
        end
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= sum_beat;
        end
    end

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg != 2'd3)
        else $error("result queue count out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        beat_pop && beat.last |=> !stopped_reg && !have_reg && repeat_reg == '0)
        else $error("set state not cleared after last beat");

    a_marks_need_swing: assert property (@(posedge clk) disable iff (!rst_n)
        !have_reg |-> !up_reg.valid && !down_reg.valid)
        else $error("direction mark valid without recorded swing");

    a_repeat_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        beat_pop && !beat.last |=> repeat_reg >= $past(repeat_reg))
        else $error("repeat count decreased inside a set");

endmodule

[test/tb_price_swing_cycle_tracker.sv]
// ----------------------------------------------------------------------------
// tb_price_swing_cycle_tracker
// Self-checking bench: pivot sets go in newest first, each set summary is
// compared field by field with a cycle-free tracker model kept in step with
// every accepted beat. A directed table opens the run, random sets follow
// under several register settings and idle mixes, then one long set.
// ----------------------------------------------------------------------------
module tb_price_swing_cycle_tracker;
    import pst_pkg::*;

    typedef struct {
        logic [31:0] bar;
        logic [31:0] price;
        logic [31:0] tm;
        logic        last;
        bit          typed;
        summary_t    want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    pivot_t            pivot;
    logic              full;
    logic              pop;
    logic              empty;
    summary_t          summary;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // tracker model state
    bit                  first_pending;
    int unsigned         depth;
    logic [BAR_W-1:0]    head_bar;
    logic [PRICE_W-1:0]  lo_px, hi_px;
    logic [TIME_W-1:0]   lo_t, hi_t;
    int unsigned         lo_at, hi_at;
    mark_t               up_mark, dn_mark;
    logic [STABLE_W-1:0] repeats;
    bit                  halted;
    bit                  any_swing;
    swing_t              freshest, earliest;
    logic [BACK_W-1:0]   back_bars;
    logic [STABLE_W-1:0] stable_need;

    summary_t summary_q[$];
    row_t     plan[$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors    = 0;
    int n_pivots  = 0;
    int n_sets    = 0;
    int n_checked = 0;
    int n_stops   = 0;

    price_swing_cycle_tracker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pivot   (pivot),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .summary (summary),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function void clear_tracker();
        first_pending = 1'b1;
        depth         = 0;
        head_bar      = '0;
        lo_px         = '0;
        hi_px         = '0;
        lo_t          = '0;
        hi_t          = '0;
        lo_at         = 0;
        hi_at         = 0;
        up_mark       = '0;
        dn_mark       = '0;
        repeats       = '0;
        halted        = 1'b0;
        any_swing     = 1'b0;
        freshest      = '0;
        earliest      = '0;
    endfunction

    task track_pivot(input pivot_t p, output bit ready, output summary_t s);
        swing_t cur;
        bit     rpt;
        ready = 1'b0;
        s     = '0;
        if (!halted) begin
            if (first_pending) begin
                first_pending = 1'b0;
                head_bar      = p.bar_index;
                depth         = 0;
                lo_px         = p.pivot_price;
                hi_px         = p.pivot_price;
                lo_t          = p.pivot_time;
                hi_t          = p.pivot_time;
                lo_at         = 0;
                hi_at         = 0;
            end
            else if (depth + 1 < MAX_PIVOTS) begin
                depth++;
                if (p.pivot_price <= lo_px) begin
                    lo_px = p.pivot_price;
                    lo_t  = p.pivot_time;
                    lo_at = depth;
                end
                if (p.pivot_price >= hi_px) begin
                    hi_px = p.pivot_price;
                    hi_t  = p.pivot_time;
                    hi_at = depth;
                end
                if (hi_at < lo_at)
                    cur = {lo_t, hi_t, lo_px, hi_px, 1'b1};
                else
                    cur = {hi_t, lo_t, hi_px, lo_px, 1'b0};
                rpt = (cur.rising ? up_mark : dn_mark)
                      == {1'b1, cur.begin_price, cur.finish_price};
                if (rpt) begin
                    if (repeats != REPEAT_MAX)
                        repeats++;
                end
                else begin
                    if (cur.rising)
                        up_mark = {1'b1, cur.begin_price, cur.finish_price};
                    else
                        dn_mark = {1'b1, cur.begin_price, cur.finish_price};
                    if (!any_swing) begin
                        any_swing = 1'b1;
                        freshest  = cur;
                        earliest  = cur;
                    end
                    else begin
                        if (cur.finish_time > freshest.finish_time)
                            freshest = cur;
                        if (cur.finish_time < earliest.finish_time)
                            earliest = cur;
                    end
                end
                if ({1'b0, p.bar_index} + 33'(back_bars) < {1'b0, head_bar}
                    && repeats >= stable_need) begin
                    halted = 1'b1;
                    n_stops++;
                end
            end
        end
        if (p.oldest_pivot) begin
            ready = 1'b1;
            if (any_swing)
                s = {1'b1, freshest, earliest};
            clear_tracker();
        end
    endtask

    task send_pivot(input pivot_t p, input bit typed, input summary_t typed_sum);
        bit       ready;
        summary_t s;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        pivot <= p;
        do
            @(posedge clk);
        while (full);
        n_pivots++;
        track_pivot(p, ready, s);
        if (ready) begin
            n_sets++;
            summary_q = {summary_q, (typed ? typed_sum : s)};
        end
    endtask

    task drain();
        int guard;
        push  <= 1'b0;
        guard = 0;
        while (summary_q.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task program_limits(input logic [BACK_W-1:0] back, input logic [STABLE_W-1:0] stable);
        write_reg(REG_BACK_LIMIT, DATA_W'(back));
        write_reg(REG_STABLE_LIMIT, DATA_W'(stable));
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        back_bars   = back;
        stable_need = stable;
    endtask

    task random_set();
        int unsigned       len;
        int unsigned       kind;
        logic [31:0]       bar;
        logic [31:0]       tm;
        logic [31:0]       base;
        logic [31:0]       pal[4];
        pivot_t            p;
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 20);
        bar  = $urandom();
        tm   = $urandom();
        base = $urandom();
        foreach (pal[k]) begin
            case ($urandom_range(0, 9))
                0:       pal[k] = '0;
                1:       pal[k] = '1;
                default: pal[k] = base + $urandom_range(0, 8);
            endcase
        end
        for (int i = 0; i < len; i++) begin
            if (kind == 0) begin
                p.bar_index   = $urandom();
                p.pivot_price = $urandom();
                p.pivot_time  = $urandom();
            end
            else begin
                if (kind == 1) begin
                    bar = bar + $urandom_range(0, 50);
                    tm  = $urandom();
                end
                else if (i != 0) begin
                    bar = bar - $urandom_range(0, 40);
                    tm  = tm - $urandom_range(0, 3);
                end
                p.bar_index   = bar;
                p.pivot_price = pal[$urandom_range(0, 3)];
                p.pivot_time  = tm;
            end
            p.oldest_pivot = (i == len - 1);
            send_pivot(p, 1'b0, '0);
        end
    endtask

    task long_set(input int unsigned count, input logic [31:0] first_bar,
                  input logic [31:0] rest_bar);
        pivot_t p;
        for (int unsigned i = 0; i < count; i++) begin
            p.bar_index    = (i == 0) ? first_bar : rest_bar;
            p.pivot_price  = (i + 4 < count) ? 32'd1000 : ((i % 2) ? '1 : '0);
            p.pivot_time   = $urandom();
            p.oldest_pivot = (i == count - 1);
            send_pivot(p, 1'b0, '0);
        end
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    function void add_row(input logic [31:0] bar, input logic [31:0] price,
                          input logic [31:0] tm, input logic last,
                          input bit typed, input summary_t want);
        row_t r;
        r.bar   = bar;
        r.price = price;
        r.tm    = tm;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        plan = {plan, r};
    endfunction

    initial begin
        summary_t want;
        pop <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty) begin
                if (summary_q.size() == 0) begin
                    errors++;
                    $display("%0t: summary beat with none expected, actual %h",
                             $time, summary);
                end
                else begin
                    want = summary_q.pop_front();
                    n_checked++;
                    check_field("found_any", summary.found_any, want.found_any);
                    check_field("fresh_begin_time", summary.fresh_begin_time,
                                want.fresh_begin_time);
                    check_field("fresh_finish_time", summary.fresh_finish_time,
                                want.fresh_finish_time);
                    check_field("fresh_begin_price", summary.fresh_begin_price,
                                want.fresh_begin_price);
                    check_field("fresh_finish_price", summary.fresh_finish_price,
                                want.fresh_finish_price);
                    check_field("fresh_rising", summary.fresh_rising, want.fresh_rising);
                    check_field("main_begin_time", summary.main_begin_time,
                                want.main_begin_time);
                    check_field("main_finish_time", summary.main_finish_time,
                                want.main_finish_time);
                    check_field("main_begin_price", summary.main_begin_price,
                                want.main_begin_price);
                    check_field("main_finish_price", summary.main_finish_price,
                                want.main_finish_price);
                    check_field("main_rising", summary.main_rising, want.main_rising);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        swing_t up_full;
        int     goal;
        rst_n   <= 1'b0;
        push    <= 1'b0;
        pivot   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        clear_tracker();
        back_bars     = MIN_BACK_RST;
        stable_need   = MIN_STABLE_RST;
        send_idle_pct = 33;
        recv_idle_pct = 57;
        up_full = {32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1};

        // single-pivot sets
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '0);
        add_row(32'd0, 32'd0, 32'd0, 1'b1, 1'b1, '0);
        // flat prices: equal positions, then a repeat
        add_row(32'd100, 32'd5, 32'd300, 1'b0, 1'b0, '0);
        add_row(32'd99, 32'd5, 32'd200, 1'b0, 1'b0, '0);
        add_row(32'd98, 32'd5, 32'd100, 1'b1, 1'b0, '0);
        // full-range up swing
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'd0, 32'd0, 32'd0, 1'b1, 1'b1, {1'b1, up_full, up_full});
        // early stop under reset limits, trailing pivot ignored
        add_row(32'd1000, 32'd50, 32'd900, 1'b0, 1'b0, '0);
        for (int i = 1; i <= 8; i++)
            add_row(32'd600, 32'd50, 32'(900 - i), 1'b0, 1'b0, '0);
        add_row(32'd600, 32'd0, 32'd1, 1'b1, 1'b0, '0);
        // end-time ties between up and down swings
        add_row(32'd50, 32'd10, 32'd100, 1'b0, 1'b0, '0);
        add_row(32'd49, 32'd20, 32'd100, 1'b0, 1'b0, '0);
        add_row(32'd48, 32'd5, 32'd50, 1'b0, 1'b0, '0);
        add_row(32'd47, 32'd30, 32'd200, 1'b1, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_pivot({plan[k].bar, plan[k].price, plan[k].tm, plan[k].last},
                       plan[k].typed, plan[k].want);

        for (int chunk = 0; chunk < 6; chunk++) begin
            send_idle_pct = (chunk < 2) ? 33 : (chunk < 4) ? 57 : 0;
            recv_idle_pct = (chunk < 2) ? 57 : (chunk < 4) ? 33 : 0;
            drain();
            case (chunk)
                0:       program_limits(16'd0, 8'd0);
                1:       program_limits(16'hFFFF, 8'hFF);
                2:       program_limits(BACK_W'($urandom()), STABLE_W'($urandom()));
                3:       program_limits(16'd8, 8'd2);
                4:       program_limits(16'd40, 8'd5);
                default: program_limits(BACK_W'($urandom_range(0, 100)),
                                        STABLE_W'($urandom_range(0, 12)));
            endcase
            goal = n_pivots + 200;
            while (n_pivots < goal)
                random_set();
        end

        drain();
        program_limits(16'hFFFF, 8'hFF);
        long_set(300, 32'd200000, 32'd100000);
        drain();

        if (summary_q.size() != 0) begin
            errors += summary_q.size();
            $display("%0t: %0d summaries never arrived", $time, summary_q.size());
        end
        $display("Checked %0d summaries from %0d pivots in %0d sets, %0d early stops,",
                 n_checked, n_pivots, n_sets, n_stops);
        $display("six register settings plus a long saturating set; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/pst_pkg.sv
hdl/pst_cfg.sv
hdl/pst_front.sv
hdl/pst_queue.sv
hdl/pst_back.sv
hdl/price_swing_cycle_tracker.sv
test/tb_price_swing_cycle_tracker.sv
